FILE: src/u8sdv_pkg.sv
// ----------------------------------------------------------------------------
// u8sdv_pkg
// Shared types and constants for the UTF-8 stream decoder and validator.
// ----------------------------------------------------------------------------
package u8sdv_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BAD_CONT  = 2'd2,
        ST_TRUNC     = 2'd3
    } status_t;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;

    // continuation byte tag and ASCII upper bound
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [7:0] ASCII_TOP = 8'h80;

    // lead bytes that restrict the first continuation byte
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;
    localparam logic [7:0] MIN_AFTER_E0 = 8'hA0;
    localparam logic [7:0] MIN_AFTER_F0 = 8'h90;
    localparam logic [7:0] MAX_AFTER_F4 = 8'h8F;

    // decoder sequence state
    typedef struct packed {
        logic [1:0]       bytes_pending;
        logic [CP_W-1:0]  code_accum;
        logic [7:0]       lead_value;
        logic [LEN_W-1:0] sequence_len;
        logic             first_cont_next;
        logic             error_seen;
    } dec_state_t;

    // one result beat
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        status_t          status;
        logic             string_done;
        logic             string_valid;
    } result_t;

endpackage

FILE: src/utf8_stream_decoder_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_validator_core
// UTF-8 byte stream decoder with per-character status and string verdict.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle and sustains one byte per cycle while the output
// register is free to take each result. Each byte is captured in an input
// register, decoded against the sequence state in one short combinational
// step, and any result lands in the output register. Bytes inside a
// multi-byte sequence give no beat; a finished or failed character gives
// one, as does a string that ends mid-sequence. The output register lets
// the next byte enter while a result still waits downstream.
module utf8_stream_decoder_validator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_code_point,
    output logic [2:0]  m_seq_length,
    output logic [1:0]  m_status,
    output logic        m_string_done,
    output logic        m_string_valid
);
    import u8sdv_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    dec_state_t state_reg;
    dec_state_t state_next;
    result_t    dec_res;
    logic       dec_res_valid;
    result_t    out_res;
    logic       out_free;
    logic       advance;

    // input stage moves on when its result has somewhere to go
    assign advance = in_valid_reg && (!dec_res_valid || out_free);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // input beat payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eos_reg  <= s_end_of_string;
        end
    end

    u8sdv_decode u_decode (
        .state_i     (state_reg),
        .data_byte_i (in_byte_reg),
        .eos_i       (in_eos_reg),
        .state_o     (state_next),
        .res_o       (dec_res),
        .res_valid_o (dec_res_valid)
    );

    u8sdv_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_i    (advance && dec_res_valid),
        .res_i     (dec_res),
        .m_ready_i (m_ready),
        .free_o    (out_free),
        .m_valid_o (m_valid),
        .res_o     (out_res)
    );

    // result beat fields
    assign m_code_point   = out_res.code_point;
    assign m_seq_length   = out_res.seq_length;
    assign m_status       = out_res.status;
    assign m_string_done  = out_res.string_done;
    assign m_string_valid = out_res.string_valid;

endmodule

FILE: src/u8sdv_decode.sv
// ----------------------------------------------------------------------------
// u8sdv_decode
// Single-byte decode step: current sequence state and one byte in, next
// state and an optional result out.
// ----------------------------------------------------------------------------
module u8sdv_decode (
    input  u8sdv_pkg::dec_state_t state_i,
    input  logic [7:0]            data_byte_i,
    input  logic                  eos_i,
    output u8sdv_pkg::dec_state_t state_o,
    output u8sdv_pkg::result_t    res_o,
    output logic                  res_valid_o
);
    import u8sdv_pkg::*;

    dec_state_t       st;
    logic             emit;
    status_t          stat;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             range_bad;
    logic [CP_W-1:0]  accum_shift;
    logic [1:0]       pending_dec;
    logic             bad;

    // restrictions on the first continuation byte after E0, F0 and F4 leads
    assign range_bad = (state_i.lead_value == LEAD_E0 && data_byte_i < MIN_AFTER_E0)
                    || (state_i.lead_value == LEAD_F0 && data_byte_i < MIN_AFTER_F0)
                    || (state_i.lead_value == LEAD_F4 && data_byte_i > MAX_AFTER_F4);

    assign accum_shift = {state_i.code_accum[CP_W-7:0], data_byte_i[5:0]};
    assign pending_dec = state_i.bytes_pending - 2'd1;

    // byte classification and accumulation
    always_comb begin
        st   = state_i;
        emit = 1'b0;
        stat = ST_OK;
        cp   = '0;
        len  = '0;
        if (state_i.bytes_pending == 2'd0) begin
            if (data_byte_i < ASCII_TOP) begin
                emit = 1'b1;
                cp   = {13'd0, data_byte_i};
                len  = 3'd1;
            end else if (data_byte_i inside {[8'hC2:8'hDF]}) begin
                st.code_accum    = {16'd0, data_byte_i[4:0]};
                st.sequence_len  = 3'd2;
                st.bytes_pending = 2'd1;
            end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
                st.code_accum    = {17'd0, data_byte_i[3:0]};
                st.sequence_len  = 3'd3;
                st.bytes_pending = 2'd2;
            end else if (data_byte_i inside {[8'hF0:8'hF4]}) begin
                st.code_accum    = {18'd0, data_byte_i[2:0]};
                st.sequence_len  = 3'd4;
                st.bytes_pending = 2'd3;
            end else begin
                emit = 1'b1;
                stat = ST_BAD_START;
            end
            if (st.bytes_pending != 2'd0) begin
                st.lead_value      = data_byte_i;
                st.first_cont_next = 1'b1;
                if (eos_i) begin
                    emit = 1'b1;
                    stat = ST_TRUNC;
                end
            end
        end else if (data_byte_i[7:6] != CONT_TAG
                     || (state_i.first_cont_next && range_bad)) begin
            emit = 1'b1;
            stat = ST_BAD_CONT;
        end else begin
            st.first_cont_next = 1'b0;
            st.code_accum      = accum_shift;
            st.bytes_pending   = pending_dec;
            if (pending_dec == 2'd0) begin
                emit = 1'b1;
                cp   = accum_shift;
                len  = state_i.sequence_len;
                st.code_accum   = '0;
                st.lead_value   = '0;
                st.sequence_len = '0;
            end else if (eos_i) begin
                emit = 1'b1;
                stat = ST_TRUNC;
            end
        end
    end

    assign bad = (stat != ST_OK);

    // result assembly and string / error bookkeeping
    always_comb begin
        state_o = st;
        res_o.code_point   = cp;
        res_o.seq_length   = len;
        res_o.status       = stat;
        res_o.string_done  = eos_i;
        res_o.string_valid = eos_i && !(state_i.error_seen || bad);
        if (emit) begin
            if (bad || eos_i) begin
                state_o.bytes_pending   = '0;
                state_o.code_accum      = '0;
                state_o.lead_value      = '0;
                state_o.sequence_len    = '0;
                state_o.first_cont_next = 1'b0;
            end
            if (eos_i) begin
                state_o.error_seen = 1'b0;
            end else if (bad) begin
                state_o.error_seen = 1'b1;
            end
        end
    end

    assign res_valid_o = emit;

endmodule

FILE: src/u8sdv_out_reg.sv
// ----------------------------------------------------------------------------
// u8sdv_out_reg
// Result register: holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8sdv_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_i,
    input  u8sdv_pkg::result_t res_i,
    input  logic               m_ready_i,
    output logic               free_o,
    output logic               m_valid_o,
    output u8sdv_pkg::result_t res_o
);
    import u8sdv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // slot is free when empty or being drained this cycle
    assign free_o = !valid_reg || m_ready_i;

    always_comb begin
        valid_next = valid_reg;
        if (load_i) begin
            valid_next = 1'b1;
        end else if (m_ready_i) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

    assign m_valid_o = valid_reg;
    assign res_o     = res_reg;

endmodule

FILE: src/u8sdv_checker.sv
// ----------------------------------------------------------------------------
// u8sdv_checker
// Port-level checks on the decoder result channel, bound to the top level.
// ----------------------------------------------------------------------------
module u8sdv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [20:0] m_code_point,
    input logic [2:0]  m_seq_length,
    input logic [1:0]  m_status,
    input logic        m_string_done,
    input logic        m_string_valid
);
    import u8sdv_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point)
            && $stable(m_seq_length) && $stable(m_status)
            && $stable(m_string_done) && $stable(m_string_valid))
        else $error("result beat changed while stalled");

    // error beats carry no character
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_code_point == 21'd0 && m_seq_length == 3'd0)
        else $error("error beat with nonzero code point or length");

    // ok beats carry a length of one to four and a scalar in range
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_seq_length != 3'd0 && m_seq_length <= 3'd4
            && m_code_point <= 21'h10FFFF)
        else $error("ok beat with bad length or code point");

    // verdict only on a closing beat, and never on an error beat
    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_valid |-> m_string_done && m_status == ST_OK)
        else $error("string valid outside a clean closing beat");

endmodule

bind utf8_stream_decoder_validator_core u8sdv_checker u_u8sdv_checker (.*);
